// ===== design/sps_pkg.sv =====
// Shared types and constants for the synced phasor block.
`timescale 1ns / 1ps

package sps_pkg;

    localparam int SPEED_BITS = 6;
    localparam int MODE_BITS  = 4;

    typedef logic signed [SPEED_BITS-1:0] speed_t;

    localparam speed_t SPEED_ONE = 6'sd4;

    // Sync mode codes as written to the mode register.
    typedef enum logic [MODE_BITS-1:0] {
        MODE_HARD     = 4'd0,
        MODE_FIFTH    = 4'd1,
        MODE_OCTAVE   = 4'd2,
        MODE_SUBOCT   = 4'd3,
        MODE_RISE_A   = 4'd4,
        MODE_RISE_B   = 4'd5,
        MODE_FALL_A   = 4'd6,
        MODE_FALL_B   = 4'd7,
        MODE_PULL_A   = 4'd8,
        MODE_PULL_B   = 4'd9,
        MODE_PUSH_A   = 4'd10,
        MODE_PUSH_B   = 4'd11,
        MODE_HOLD     = 4'd12,
        MODE_ONESHOT  = 4'd13,
        MODE_LOCKSHOT = 4'd14,
        MODE_REVERSE  = 4'd15
    } mode_t;

    // Register indexes on the configuration port.
    localparam logic REG_SYNC_ENABLE = 1'b0;
    localparam logic REG_SYNC_MODE   = 1'b1;

    // Control state carried from sample to sample.
    typedef struct packed {
        speed_t speed;
        logic   gate;
        logic   sync_was_high;
        logic   wrapped_fwd;
    } ctl_t;

endpackage

// ===== design/sps_step.sv =====
// Per-sample sync and phase advance logic (combinational).
`timescale 1ns / 1ps

module sps_step #(
    parameter int PHASE_BITS = 32
) (
    input  logic                  sync_enable,
    input  sps_pkg::mode_t        sync_mode,
    input  logic [PHASE_BITS-1:0] phase,
    input  sps_pkg::ctl_t         ctl,
    input  logic [31:0]           phase_increment,
    input  logic [31:0]           phase_mod,
    input  logic signed [15:0]    sync_sample,
    output logic [PHASE_BITS-1:0] phase_next,
    output sps_pkg::ctl_t         ctl_next,
    output logic [31:0]           read_phase,
    output logic [31:0]           phasor,
    output logic                  end_of_cycle
);

    localparam int W  = (PHASE_BITS > 32) ? PHASE_BITS : 32;
    localparam int UP = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
    localparam int DN = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
    localparam int PW = PHASE_BITS + 6;   // product width
    localparam int DW = PHASE_BITS + 4;   // step width after the quarter shift

    function automatic logic [PHASE_BITS-1:0] from32(input logic [31:0] v);
        logic [W-1:0] t;
        t = W'(v) << UP;
        t = t >> DN;
        return t[PHASE_BITS-1:0];
    endfunction

    function automatic logic [31:0] to32(input logic [PHASE_BITS-1:0] v);
        logic [W-1:0] t;
        t = W'(v) >> UP;
        t = t << DN;
        return t[31:0];
    endfunction

    localparam logic [PHASE_BITS-1:0] QUARTER = from32(32'h4000_0000);
    localparam logic [PHASE_BITS-1:0] HALF    = from32(32'h8000_0000);

    logic                  high;
    logic                  edge_det;
    logic [PHASE_BITS-1:0] ph;
    logic signed [7:0]     q;
    logic signed [7:0]     t3;
    logic                  g;
    logic [PHASE_BITS-1:0] ph_read;
    logic [31:0]           inc_clamped;
    logic [PHASE_BITS-1:0] inc_s;
    logic [5:0]            mag;
    logic [PW-1:0]         prod;
    logic [DW-1:0]         delta;
    logic [DW:0]           sum;
    logic                  fwd;
    logic                  eoc;
    logic [PHASE_BITS-1:0] ph_adv;

    assign high     = (sync_sample > 16'sd0);
    assign edge_det = high && !ctl.sync_was_high;

    // sync stage
    always_comb
    begin
        ph = phase;
        q  = 8'(ctl.speed);
        g  = ctl.gate;
        t3 = 8'(q * 8'sd3);
        if (sync_enable)
        begin
            case (sync_mode)
                sps_pkg::MODE_HARD:
                begin
                    if (edge_det) ph = '0;
                end
                sps_pkg::MODE_FIFTH:
                begin
                    // C division truncates toward zero
                    if (edge_det) q = (t3 + ((t3 < 0) ? 8'sd1 : 8'sd0)) >>> 1;
                    if (q > 8'sd6) q = 8'sd4;
                end
                sps_pkg::MODE_OCTAVE:
                begin
                    if (edge_det) q = q <<< 1;
                    if (q > 8'sd8) q = 8'sd4;
                end
                sps_pkg::MODE_SUBOCT:
                begin
                    if (edge_det) q = (q + ((q < 0) ? 8'sd1 : 8'sd0)) >>> 1;
                    if (q < 8'sd2) q = 8'sd4;
                end
                sps_pkg::MODE_RISE_A:
                begin
                    if (edge_det) q = q + 8'sd2;
                    if (q > 8'sd8) q = 8'sd4;
                end
                sps_pkg::MODE_RISE_B:
                begin
                    if (edge_det) q = q + 8'sd2;
                    if (q > 8'sd16) q = 8'sd4;
                end
                sps_pkg::MODE_FALL_A:
                begin
                    if (edge_det) q = q - 8'sd2;
                    if (q < 8'sd4) q = 8'sd8;
                end
                sps_pkg::MODE_FALL_B:
                begin
                    if (edge_det) q = q - 8'sd2;
                    if (q < 8'sd4) q = 8'sd16;
                end
                sps_pkg::MODE_PULL_A:
                begin
                    if (edge_det) ph = ph - HALF;
                end
                sps_pkg::MODE_PULL_B:
                begin
                    if (edge_det) ph = ph - QUARTER;
                end
                sps_pkg::MODE_PUSH_A:
                begin
                    if (edge_det) ph = ph + QUARTER;
                end
                sps_pkg::MODE_PUSH_B:
                begin
                    if (edge_det) ph = ph + HALF;
                end
                sps_pkg::MODE_HOLD:
                begin
                    if (edge_det) q = q - 8'sd4;
                    if (q < 8'sd0) q = 8'sd4;
                end
                sps_pkg::MODE_ONESHOT, sps_pkg::MODE_LOCKSHOT:
                begin
                    if (ctl.wrapped_fwd)
                    begin
                        g = 1'b0;
                        q = 8'sd0;
                    end
                    if (edge_det)
                    begin
                        g = 1'b1;
                        q = 8'sd4;
                        if (sync_mode == sps_pkg::MODE_ONESHOT) ph = '0;
                    end
                    // parked at phase zero until re-triggered
                    if (q != 8'sd4) ph = '0;
                end
                default:
                begin
                    if (edge_det) q = -q;
                end
            endcase
        end
        else
        begin
            q = 8'sd4;
            g = 1'b1;
        end
    end

    assign ph_read = ph + from32(phase_mod);

    // advance stage
    assign inc_clamped = (phase_increment > 32'h8000_0000) ? 32'h8000_0000 : phase_increment;
    assign inc_s       = from32(inc_clamped);
    assign mag         = q[7] ? 6'(-q) : 6'(q);
    assign prod        = PW'(inc_s) * PW'(mag);
    assign delta       = prod[PW-1:2];
    assign sum         = (DW+1)'(ph) + (DW+1)'(delta);

    always_comb
    begin
        fwd    = 1'b0;
        eoc    = 1'b0;
        ph_adv = ph;
        if (!q[7] && (q != 8'sd0))
        begin
            fwd    = |sum[DW:PHASE_BITS];
            eoc    = fwd;
            ph_adv = sum[PHASE_BITS-1:0];
        end
        else if (q[7])
        begin
            eoc    = delta > DW'(ph);
            ph_adv = ph - delta[PHASE_BITS-1:0];
        end
    end

    assign phase_next             = ph_adv;
    assign ctl_next.speed         = q[5:0];
    assign ctl_next.gate          = g;
    assign ctl_next.sync_was_high = high;
    assign ctl_next.wrapped_fwd   = fwd;

    assign read_phase   = to32(ph_read);
    assign phasor       = to32(ph_adv);
    assign end_of_cycle = eoc;

endmodule

// ===== design/synced_phasor_with_sync_modes.sv =====
// Top level of the synced phasor: stream channels, state and config registers.
`timescale 1ns / 1ps

// Synced phasor with sixteen sync modes.
//
// Input stream (s_*): one transaction per audio sample carrying the phase
// increment, the phase offset and the sync source sample. Output stream
// (m_*): one transaction per input sample with the read phase, the advanced
// phasor, the speed in quarter units and the gate; m_tlast flags that the
// advance crossed a cycle boundary.
// Config port: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 sync enable, 1 sync mode) at the clock edge. A mode change resets
// speed to one and opens the gate. Write only while the block is idle.
//
// Pipeline: an input transaction is taken into the input register, then its
// result into the result register (two register stages), and goes out on m_*.
// Throughput: one sample per cycle unless m_tready stalls; the phase/speed
// recurrence closes through the sync logic and a phase-by-6-bit multiply.
// Back-pressure: when m_tready is low the result register holds, the input
// register still takes one more sample, then s_tready drops.
// Reset: both stages empty, phase 0, speed one, gate open, sync disabled,
// mode hard.

module synced_phasor_with_sync_modes #(
    parameter int PHASE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // phase_increment[31:0], phase_mod[63:32],
                                   // sync_sample[79:64]
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // read_phase[31:0], phasor[63:32],
                                   // speed[69:64], gate[70], zero[71]
    output logic        m_tlast,   // end_of_cycle
    // config write port
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_wdata
);

    // input register
    logic               in_valid_reg;
    logic [31:0]        inc_reg;
    logic [31:0]        pmod_reg;
    logic signed [15:0] sample_reg;

    // result register
    logic               out_valid_reg;
    logic [31:0]        read_phase_reg;
    logic [31:0]        phasor_reg;
    logic               eoc_reg;
    sps_pkg::speed_t    speed_reg;
    logic               gate_reg;

    // phasor state and config
    logic [PHASE_BITS-1:0] phase_reg;
    sps_pkg::ctl_t         ctl_reg;
    logic                  sync_enable_reg;
    sps_pkg::mode_t        sync_mode_reg;

    logic [PHASE_BITS-1:0] phase_next;
    sps_pkg::ctl_t         ctl_next;
    logic [31:0]           read_phase_next;
    logic [31:0]           phasor_next;
    logic                  eoc_next;
    logic                  advance;
    logic                  mode_change;

    assign advance     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready    = !in_valid_reg || advance;
    assign mode_change = cfg_wr_en && (cfg_index == sps_pkg::REG_SYNC_MODE)
                         && (sps_pkg::mode_t'(cfg_wdata) != sync_mode_reg);

    sps_step #(
        .PHASE_BITS (PHASE_BITS)
    ) u_step (
        .sync_enable     (sync_enable_reg),
        .sync_mode       (sync_mode_reg),
        .phase           (phase_reg),
        .ctl             (ctl_reg),
        .phase_increment (inc_reg),
        .phase_mod       (pmod_reg),
        .sync_sample     (sample_reg),
        .phase_next      (phase_next),
        .ctl_next        (ctl_next),
        .read_phase      (read_phase_next),
        .phasor          (phasor_next),
        .end_of_cycle    (eoc_next)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            inc_reg    <= s_tdata[31:0];
            pmod_reg   <= s_tdata[63:32];
            sample_reg <= s_tdata[79:64];
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_phase_reg <= read_phase_next;
            phasor_reg     <= phasor_next;
            eoc_reg        <= eoc_next;
            speed_reg      <= ctl_next.speed;
            gate_reg       <= ctl_next.gate;
        end
    end

    // phasor state; a mode write that changes the mode resets speed and gate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= '0;
            ctl_reg.speed         <= sps_pkg::SPEED_ONE;
            ctl_reg.gate          <= 1'b1;
            ctl_reg.sync_was_high <= 1'b0;
            ctl_reg.wrapped_fwd   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= phase_next;
                ctl_reg   <= ctl_next;
            end
            if (mode_change)
            begin
                ctl_reg.speed <= sps_pkg::SPEED_ONE;
                ctl_reg.gate  <= 1'b1;
            end
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_enable_reg <= 1'b0;
            sync_mode_reg   <= sps_pkg::MODE_HARD;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                sps_pkg::REG_SYNC_ENABLE: sync_enable_reg <= cfg_wdata[0];
                sps_pkg::REG_SYNC_MODE:   sync_mode_reg   <= sps_pkg::mode_t'(cfg_wdata);
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = eoc_reg;
    assign m_tdata  = {1'b0, gate_reg, speed_reg, phasor_reg, read_phase_reg};

`ifndef ASSERT_OFF
    // a closed gate only comes from a finished shot, which stops the phasor
    a_gate_closed_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[70]) |-> (m_tdata[69:64] == 6'd0))
        else $error("gate closed with nonzero speed");

    // a stopped phasor cannot report a cycle crossing
    a_eoc_needs_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[69:64] != 6'd0))
        else $error("end of cycle at zero speed");

    // with the result stage empty the input side must never stall
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result stage");

    // a stalled result is not overwritten
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(phasor_reg)))
        else $error("stalled result lost");
`endif

endmodule

// ===== tb/tb_synced_phasor_with_sync_modes.sv =====
// Testbench for the synced phasor: directed table, then random sync streams scored by a model.
`timescale 1ns / 1ps

// What is checked
//   Every output transaction is compared field by field with the oldest
//   predicted sample. Fields are read phase, phasor, end of cycle (m_tlast),
//   speed, gate and the zero pad bit of m_tdata.
//
// How
//   - A directed table runs first. Rows cover the reset state, the step and
//     offset extremes, the clamp of the increment, and at least one row per sync mode.
//     The table also covers the one-shot wrap and restart, a backward cross
//     in reverse, and a write to the enable register with its unused bits set.
//     Rows whose result is obvious carry a typed expectation; the other rows
//     are scored by the predictor.
//   - Random phases follow, one per sync mode, plus a phase with sync off and
//     a phase that rewrites the mode already in use. The sync input is a
//     square wave with random run lengths and levels, with some noise mixed in.
//   - The sender works in bursts with random gaps. The receiver switches
//     between several stall patterns. Once the receiver holds off for a long
//     stretch so that both stages fill and s_tready drops.
//   - Registers are written only once the pipe has drained.
//   - A watchdog ends the run when no transaction moves for too long.

module tb_synced_phasor_with_sync_modes;

    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
    localparam int RAND_PHASES    = 18;
    localparam int PHASE_ITEMS    = 45;
    localparam int PIPE_FLUSH     = 10;    // two stages plus margin

    localparam logic [31:0] HALF_CYCLE    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_CYCLE = 32'h4000_0000;

    // One predicted output sample.
    typedef struct packed {
        logic [31:0]     read_phase;
        logic [31:0]     phasor;
        logic            eoc;
        sps_pkg::speed_t speed;
        logic            gate;
    } phasor_out_t;

    // One row of the directed table. When set_cfg is high, the pipe is
    // drained and both registers are written before the sample goes out.
    typedef struct packed {
        logic           set_cfg;
        logic [3:0]     enable_word;
        sps_pkg::mode_t mode;
        logic [31:0]    inc;
        logic [31:0]    pmod;
        logic [15:0]    sync;
        logic           typed;
        phasor_out_t    want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // phase_increment[31:0], phase_mod[63:32], sync_sample[79:64]
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // read_phase[31:0], phasor[63:32], speed[69:64], gate[70],
                            // zero[71]
    logic        m_tlast;   // end_of_cycle
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [3:0]  cfg_wdata;

    // Predictor state, mirrors the block's registers.
    logic [31:0]    cur_phase;
    int             cur_speed;       // quarter units
    logic           cur_gate;
    logic           sync_hi_last;
    logic           fwd_wrap_last;
    logic           cur_enable;
    sps_pkg::mode_t cur_mode;

    phasor_out_t phasor_out_q[$];
    dir_row_t    dir_rows[$];

    int   mismatches  = 0;
    int   idle_cycles = 0;
    int   burst_left  = 0;
    logic no_gaps     = 1'b0;
    logic hold_req    = 1'b0;

    always #10 clk = ~clk;

    synced_phasor_with_sync_modes #(
        .PHASE_BITS(32)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor: sync edge detect, mode effect, read phase, advance.
    // ------------------------------------------------------------------
    task automatic advance_phasor(input logic [31:0] inc, input logic [31:0] pmod,
                                  input logic [15:0] smp, output phasor_out_t r);
        logic        hi;
        logic        rise;
        logic        fwd;
        logic        eoc;
        int          q;
        logic [31:0] inc_c;
        logic [63:0] mag;
        logic [63:0] step_amt;
        logic [63:0] total;

        hi           = ($signed(smp) > 0);
        rise         = hi && !sync_hi_last;
        sync_hi_last = hi;
        fwd          = 1'b0;
        eoc          = 1'b0;

        if (cur_enable)
        begin
            q = cur_speed;
            case (cur_mode)
                sps_pkg::MODE_HARD:    if (rise) cur_phase = '0;
                sps_pkg::MODE_FIFTH:
                begin
                    if (rise) q = q * 3 / 2;
                    if (q > 6) q = 4;
                end
                sps_pkg::MODE_OCTAVE:
                begin
                    if (rise) q = q * 2;
                    if (q > 8) q = 4;
                end
                sps_pkg::MODE_SUBOCT:
                begin
                    if (rise) q = q / 2;
                    if (q < 2) q = 4;
                end
                sps_pkg::MODE_RISE_A:
                begin
                    if (rise) q = q + 2;
                    if (q > 8) q = 4;
                end
                sps_pkg::MODE_RISE_B:
                begin
                    if (rise) q = q + 2;
                    if (q > 16) q = 4;
                end
                sps_pkg::MODE_FALL_A:
                begin
                    if (rise) q = q - 2;
                    if (q < 4) q = 8;
                end
                sps_pkg::MODE_FALL_B:
                begin
                    if (rise) q = q - 2;
                    if (q < 4) q = 16;
                end
                // phase offsets wrap mod one cycle, no end-of-cycle flag
                sps_pkg::MODE_PULL_A:  if (rise) cur_phase = cur_phase - HALF_CYCLE;
                sps_pkg::MODE_PULL_B:  if (rise) cur_phase = cur_phase - QUARTER_CYCLE;
                sps_pkg::MODE_PUSH_A:  if (rise) cur_phase = cur_phase + QUARTER_CYCLE;
                sps_pkg::MODE_PUSH_B:  if (rise) cur_phase = cur_phase + HALF_CYCLE;
                sps_pkg::MODE_HOLD:
                begin
                    if (rise) q = q - 4;
                    if (q < 0) q = 4;
                end
                sps_pkg::MODE_ONESHOT, sps_pkg::MODE_LOCKSHOT:
                begin
                    // a forward wrap last sample stops the shot; an edge restarts it
                    if (fwd_wrap_last)
                    begin
                        cur_gate = 1'b0;
                        q        = 0;
                    end
                    if (rise)
                    begin
                        cur_gate = 1'b1;
                        q        = 4;
                        if (cur_mode == sps_pkg::MODE_ONESHOT) cur_phase = '0;
                    end
                    if (q != 4) cur_phase = '0;
                end
                default:               if (rise) q = -q;   // reverse
            endcase
            cur_speed = q;
        end
        else
        begin
            cur_speed = 4;
            cur_gate  = 1'b1;
        end

        r.read_phase = cur_phase + pmod;

        inc_c    = (inc > HALF_CYCLE) ? HALF_CYCLE : inc;
        mag      = (cur_speed < 0) ? 64'(-cur_speed) : 64'(cur_speed);
        step_amt = ({32'd0, inc_c} * mag) >> 2;
        if (cur_speed > 0)
        begin
            total     = {32'd0, cur_phase} + step_amt;
            fwd       = (total[63:32] != 0);
            eoc       = fwd;
            cur_phase = total[31:0];
        end
        else if (cur_speed < 0)
        begin
            eoc       = (step_amt > {32'd0, cur_phase});
            cur_phase = cur_phase - step_amt[31:0];
        end
        fwd_wrap_last = fwd;

        r.phasor = cur_phase;
        r.eoc    = eoc;
        r.speed  = sps_pkg::speed_t'(cur_speed);
        r.gate   = cur_gate;
    endtask

    function automatic phasor_out_t mk_out(input logic [31:0] rp, input logic [31:0] ph,
                                           input logic eoc, input int spd, input logic g);
        phasor_out_t r;
        r.read_phase = rp;
        r.phasor     = ph;
        r.eoc        = eoc;
        r.speed      = sps_pkg::speed_t'(spd);
        r.gate       = g;
        return r;
    endfunction

    task automatic add_row(input logic set_cfg, input logic [3:0] en_word,
                           input sps_pkg::mode_t mode,
                           input logic [31:0] inc, input logic [31:0] pmod,
                           input logic [15:0] smp, input logic typed, input phasor_out_t want);
        dir_row_t row;
        row.set_cfg     = set_cfg;
        row.enable_word = en_word;
        row.mode        = mode;
        row.inc         = inc;
        row.pmod        = pmod;
        row.sync        = smp;
        row.typed       = typed;
        row.want        = want;
        dir_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Config port. Called at a rising edge; drives one write, then idles with
    // cfg_wr_en low so that back-to-back writes never drive it twice in one step.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == sps_pkg::REG_SYNC_ENABLE)
            cur_enable = val[0];   // upper bits are don't-care
        else if (sps_pkg::mode_t'(val) != cur_mode)
        begin
            // a new mode restarts at speed one with the gate open
            cur_mode  = sps_pkg::mode_t'(val);
            cur_speed = 4;
            cur_gate  = 1'b1;
        end
        @(posedge clk);
    endtask

    // Drop valid and wait for the pipe to empty before touching registers.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (phasor_out_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Input side. Called at a rising edge, returns at the edge that took
    // the transaction. Handshake is sampled at the falling edge, where
    // every signal has settled; the following rising edge accepts.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [31:0] inc, input logic [31:0] pmod,
                               input logic [15:0] smp, input logic typed,
                               input phasor_out_t want);
        phasor_out_t pred;
        int          gap;

        gap = 0;
        if (!no_gaps)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(1, 8);
            end
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {smp, pmod, inc};
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        advance_phasor(inc, pmod, smp, pred);
        phasor_out_q.push_back(typed ? want : pred);
        @(posedge clk);
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Output scoreboard and watchdog, sampled mid-cycle.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : scoreboard
        phasor_out_t e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (phasor_out_q.size() == 0)
                begin
                    $display("%0t: output transaction with nothing expected, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    e = phasor_out_q.pop_front();
                    check_field("read_phase", e.read_phase, m_tdata[31:0]);
                    check_field("phasor", e.phasor, m_tdata[63:32]);
                    check_field("end_of_cycle", {31'd0, e.eoc}, {31'd0, m_tlast});
                    check_field("speed", {26'd0, e.speed}, {26'd0, m_tdata[69:64]});
                    check_field("gate", {31'd0, e.gate}, {31'd0, m_tdata[70]});
                    check_field("pad", 32'd0, {31'd0, m_tdata[71]});
                end
            end

            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: the stall pattern is redrawn at random when its run ends; a hold
    // request keeps m_tready low for HOLD_CYCLES counted here.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int kind;
        int left;
        int tick;
        m_tready = 1'b0;
        kind     = 0;
        left     = 0;
        tick     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    kind = $urandom_range(0, 3);
                    left = $urandom_range(40, 160);
                end
                left--;
                tick++;
                case (kind)
                    0:       m_tready <= 1'b1;                          // no stalls
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
                    default: m_tready <= tick[1];                       // square wave on bit 1 of tick
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        dir_row_t       row;
        logic [31:0]    inc;
        logic [31:0]    pmod;
        logic [15:0]    smp;
        logic           sync_level;
        int             run_left;
        sps_pkg::mode_t next_mode;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;

        // state after reset
        cur_phase     = '0;
        cur_speed     = 4;
        cur_gate      = 1'b1;
        sync_hi_last  = 1'b0;
        fwd_wrap_last = 1'b0;
        cur_enable    = 1'b0;
        cur_mode      = sps_pkg::MODE_HARD;

        // Directed table. Sync is off for the first four rows.
        add_row(0, 4'h0, sps_pkg::MODE_HARD, 32'h0, 32'h0, 16'h0000, 1,
                mk_out(32'h0, 32'h0, 0, 4, 1));
        // increment above half a cycle clamps to half; offset at its top
        add_row(0, 4'h0, sps_pkg::MODE_HARD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 1,
                mk_out(32'hFFFF_FFFF, 32'h8000_0000, 0, 4, 1));
        // most negative sync sample, wrap back to zero
        add_row(0, 4'h0, sps_pkg::MODE_HARD, 32'h8000_0000, 32'h1, 16'h8000, 1,
                mk_out(32'h8000_0001, 32'h0, 1, 4, 1));
        // rising sync edge is ignored while sync is off
        add_row(0, 4'h0, sps_pkg::MODE_HARD, 32'h7FFF_FFFF, 32'h0, 16'h7FFF, 1,
                mk_out(32'h0, 32'h7FFF_FFFF, 0, 4, 1));
        // enable with unused bits set; mode rewritten with the same value
        add_row(1, 4'hF, sps_pkg::MODE_HARD, 32'h4000_0000, 32'h1234_5678, 16'h0000, 0, '0);
        // hard sync edge: phase restarts from zero
        add_row(0, 4'h1, sps_pkg::MODE_HARD, 32'h4000_0000, 32'h0, 16'h0001, 1,
                mk_out(32'h0, 32'h4000_0000, 0, 4, 1));
        add_row(1, 4'h1, sps_pkg::MODE_FIFTH,    32'h0100_0000, 32'hA5A5_A5A5, 16'h0000, 0, '0);
        add_row(1, 4'h1, sps_pkg::MODE_OCTAVE,   32'h1000_0000, 32'h0,         16'd1000, 0, '0);
        add_row(1, 4'h1, sps_pkg::MODE_SUBOCT,   32'h2000_0000, 32'hFFFF_0000, 16'h0000, 0, '0);
        add_row(1, 4'h1, sps_pkg::MODE_RISE_A,   32'h3000_0000, 32'h0,         16'h0001, 0, '0);
        add_row(1, 4'h1, sps_pkg::MODE_RISE_B,   32'h0000_0001, 32'h5A5A_5A5A, 16'h0000, 0, '0);
        add_row(1, 4'h1, sps_pkg::MODE_FALL_A,   32'h0000_0007, 32'h0,         16'h0001, 0, '0);
        add_row(1, 4'h1, sps_pkg::MODE_FALL_B,   32'h6000_0000, 32'h0,         16'hFFFF, 0, '0);
        add_row(1, 4'h1, sps_pkg::MODE_PULL_A,   32'h0,         32'h0,         16'h0001, 0, '0);
        add_row(1, 4'h1, sps_pkg::MODE_PULL_B,   32'h1111_1111, 32'h0,         16'h0000, 0, '0);
        add_row(1, 4'h1, sps_pkg::MODE_PUSH_A,   32'h2222_2222, 32'h0,         16'h0002, 0, '0);
        add_row(1, 4'h1, sps_pkg::MODE_PUSH_B,   32'h3333_3333, 32'h8000_0000, 16'h0000, 0, '0);
        // hold edge drops speed to zero: phase must not move
        add_row(1, 4'h1, sps_pkg::MODE_HOLD,     32'h7000_0000, 32'h0,         16'h7FFF, 0, '0);
        add_row(1, 4'h1, sps_pkg::MODE_REVERSE,  32'h0100_0000, 32'h0,         16'h8000, 0, '0);
        // reverse edge with a half-cycle step: backward cross
        add_row(0, 4'h1, sps_pkg::MODE_REVERSE,  32'h8000_0000, 32'h0,         16'h0005, 0, '0);
        // one-shot: run until a forward wrap, stop, then restart on an edge
        add_row(1, 4'h1, sps_pkg::MODE_ONESHOT,  32'h8000_0000, 32'h0,         16'h0000, 0, '0);
        add_row(0, 4'h1, sps_pkg::MODE_ONESHOT,  32'h8000_0000, 32'h0,         16'h0000, 0, '0);
        add_row(0, 4'h1, sps_pkg::MODE_ONESHOT,  32'h8000_0000, 32'h0,         16'h0000, 0, '0);
        add_row(0, 4'h1, sps_pkg::MODE_ONESHOT,  32'h4000_0000, 32'h0,         16'h0001, 0, '0);
        add_row(1, 4'h1, sps_pkg::MODE_LOCKSHOT, 32'hFFFF_FFFF, 32'h0,         16'h0000, 0, '0);
        // enable word with bit 0 low but upper bits set turns sync off
        add_row(1, 4'hE, sps_pkg::MODE_LOCKSHOT, 32'h0000_0001, 32'h0,         16'h0001, 0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.set_cfg)
            begin
                wait_idle();
                write_reg(sps_pkg::REG_SYNC_ENABLE, row.enable_word);
                write_reg(sps_pkg::REG_SYNC_MODE, 4'(row.mode));
            end
            send_sample(row.inc, row.pmod, row.sync, row.typed, row.want);
        end

        // Random phases: every mode in turn with sync on, then one with sync
        // off, then a rewrite of the current mode that must keep the speed.
        sync_level = 1'b0;
        run_left   = 0;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p < 16)
                next_mode = sps_pkg::mode_t'(4'(p));
            else if (p == 16)
                next_mode = sps_pkg::mode_t'(4'($urandom_range(0, 15)));
            else
                next_mode = cur_mode;
            wait_idle();
            write_reg(sps_pkg::REG_SYNC_ENABLE, {3'($urandom), (p != 16)});
            write_reg(sps_pkg::REG_SYNC_MODE, 4'(next_mode));
            no_gaps = (p == 3 || p == 5 || p == 10);
            if (p == 5)
                hold_req = 1'b1;   // back-pressure: sender keeps offering meanwhile

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // sync is a square wave with random run lengths, plus noise
                if (run_left == 0)
                begin
                    sync_level = !sync_level;
                    run_left   = $urandom_range(1, 12);
                end
                run_left--;
                if ($urandom_range(0, 9) == 0)
                    smp = 16'($urandom);
                else if (sync_level)
                    smp = ($urandom_range(0, 3) == 0) ? 16'h7FFF
                                                      : 16'($urandom_range(1, 32767));
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       smp = 16'h0000;
                        1:       smp = 16'h8000;
                        default: smp = 16'($urandom_range(32768, 65535));
                    endcase
                end

                case ($urandom_range(0, 6))
                    0:       inc = $urandom;
                    1:       inc = $urandom_range(0, 32'h0100_0000);
                    2:       inc = HALF_CYCLE - 32'd32 + 32'($urandom_range(0, 64));
                    3:       inc = 32'h0;
                    4:       inc = 32'hFFFF_FFFF;
                    default: inc = $urandom_range(32'h0800_0000, 32'h7FFF_FFFF);
                endcase
                pmod = $urandom;

                send_sample(inc, pmod, smp, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (PIPE_FLUSH) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== synced_phasor_with_sync_modes.f =====
design/sps_pkg.sv
design/sps_step.sv
design/synced_phasor_with_sync_modes.sv
tb/tb_synced_phasor_with_sync_modes.sv
